### rtl/core/pmbm_pkg.sv
// pmbm_pkg: types, constants and codes for the priority mailbox buffer manager
// no dependencies
`timescale 1ns / 1ps
package pmbm_pkg;
    localparam int SLOTS           = 8;
    localparam int WAIT_DEPTH      = 16;
    localparam int PRIORITY_LEVELS = 3;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam int FW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        EV_SENT      = 2'd0,
        EV_DELIVERED = 2'd1,
        EV_REJECTED  = 2'd2
    } t_event;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  priority_req;
        logic [3:0]  requester_tag;
        logic [31:0] message;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [3:0]  event_tag;
        logic [31:0] delivered_message;
        logic [2:0]  slot_used;
        logic        last;
    } t_out_item;
endpackage

### rtl/core/pmbm_wait_fifo.sv
// pmbm_wait_fifo: ring buffer of waiting requests, one per priority or receiver
// depends on pmbm_pkg
`timescale 1ns / 1ps
module pmbm_wait_fifo
    import pmbm_pkg::*;
#(
    parameter int DW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic [CW-1:0] o_count
);
    logic [DW-1:0] r_mem [WAIT_DEPTH];
    logic [WW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [WW-1:0] w_wix;

    always_comb begin
        if (WAIT_DEPTH == 1) begin
            w_wix = '0;
        end else begin
            w_wix = WW'((32'(r_head) + 32'(r_count)) % WAIT_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[w_wix] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_pop) begin
                r_head <= (WAIT_DEPTH == 1 || 32'(r_head) == WAIT_DEPTH - 1) ? '0 : r_head + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_data  = r_mem[r_head];
    assign o_count = r_count;
endmodule

### rtl/core/priority_mailbox_buffer_manager.sv
// priority_mailbox_buffer_manager: top level, slot lists, waiter fifos and sequencer
// depends on pmbm_pkg and pmbm_wait_fifo
//
// Usage: i_in_valid/o_in_ready take one request item (send or receive);
// o_out_valid/i_out_ready return zero, one or two event items, the final one
// flagged last. A request that must wait returns nothing now; its event
// appears later as the second item of the request that serves it.
// Sequence: the request is registered on acceptance; ST_DECODE then forms
// the first event and ST_STEP2 the second, each with one take or give in the
// shared slot-list unit. Each step waits while i_out_ready holds back a
// pending event. The sequencer works on one item at a time, so o_in_ready is
// low from acceptance until the last event is taken (or the request is queued).
// Reset: synchronous, active low; all slots free (chain 0..SLOTS-1), queue
// and wait lists empty. No clearing pass.
// Stall: a pending event is held in the output register unchanged until
// taken; the following step waits for it.
//
`timescale 1ns / 1ps
module priority_mailbox_buffer_manager
    import pmbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_STEP2  = 4'b0100,
        ST_WAIT   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_in_item r_req;

    logic [31:0]   r_msg [SLOTS];
    logic [SW-1:0] r_link [SLOTS];
    logic [SW-1:0] r_qhead, r_qtail, r_fhead;
    logic [FW-1:0] r_qcount, r_fcount;

    logic          r_out_valid;
    t_out_item     r_out;
    logic          r_step2;
    logic [PW-1:0] r_psel;

    // sender and receiver wait fifos
    logic [35:0]   w_sdata [PRIORITY_LEVELS];
    logic [CW-1:0] w_scnt [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] w_spush, w_spop;
    logic [3:0]    w_rdata;
    logic [CW-1:0] w_rcnt;
    logic          w_rpush, w_rpop;

    genvar g;
    generate
        for (g = 0; g < PRIORITY_LEVELS; g++) begin : g_snd
            pmbm_wait_fifo #(.DW(36)) u_sfifo (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_push  (w_spush[g]),
                .i_data  ({r_req.requester_tag, r_req.message}),
                .i_pop   (w_spop[g]),
                .o_data  (w_sdata[g]),
                .o_count (w_scnt[g])
            );
        end
    endgenerate

    pmbm_wait_fifo #(.DW(4)) u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rpush),
        .i_data  (r_req.requester_tag),
        .i_pop   (w_rpop),
        .o_data  (w_rdata),
        .o_count (w_rcnt)
    );

    // highest waiting priority: the lowest-numbered level with a waiting sender
    logic          w_any_wait;
    logic [PW-1:0] w_pbest;
    always_comb begin
        w_any_wait = 1'b0;
        w_pbest    = '0;
        for (int p = PRIORITY_LEVELS - 1; p >= 0; p--) begin
            if (w_scnt[p] != '0) begin
                w_any_wait = 1'b1;
                w_pbest    = PW'(p);
            end
        end
    end

    logic          w_out_free;
    logic          w_prio_ok;
    logic [CW-1:0] w_pcnt;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_prio_ok  = 32'(r_req.priority_req) < PRIORITY_LEVELS;
    assign w_pcnt     = w_prio_ok ? w_scnt[PW'(r_req.priority_req)] : '0;

    // shared slot-list unit controls
    logic          w_take, w_give, w_append;
    logic [SW-1:0] w_give_slot;
    logic [31:0]   w_app_msg;
    logic          n_out_valid;
    t_out_item     n_out;
    logic          n_step2;
    logic [PW-1:0] n_psel;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_step2     = r_step2;
        n_psel      = r_psel;
        w_take      = 1'b0;
        w_give      = 1'b0;
        w_append    = 1'b0;
        w_give_slot = r_qhead;
        w_app_msg   = r_req.message;
        w_spush     = '0;
        w_spop      = '0;
        w_rpush     = 1'b0;
        w_rpop      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (w_out_free) begin
                    n_state = ST_WAIT;
                    n_step2 = 1'b0;
                    n_out   = '0;
                    if (r_req.opcode == OP_SEND) begin
                        if (!w_prio_ok || ((w_pcnt != '0 || r_fcount == '0)
                                && 32'(w_pcnt) >= WAIT_DEPTH)) begin
                            n_out_valid          = 1'b1;
                            n_out.event_kind     = EV_REJECTED;
                            n_out.event_tag      = r_req.requester_tag;
                            n_out.last           = 1'b1;
                        end else if (w_pcnt != '0 || r_fcount == '0) begin
                            w_spush[PW'(r_req.priority_req)] = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            w_take   = 1'b1;
                            w_append = 1'b1;
                            n_out_valid       = 1'b1;
                            n_out.event_kind  = EV_SENT;
                            n_out.event_tag   = r_req.requester_tag;
                            n_out.slot_used   = 3'(r_fhead);
                            n_out.last        = (w_rcnt == '0);
                            n_step2           = (w_rcnt != '0);
                        end
                    end else begin
                        if (r_qcount == '0) begin
                            if (32'(w_rcnt) >= WAIT_DEPTH) begin
                                n_out_valid      = 1'b1;
                                n_out.event_kind = EV_REJECTED;
                                n_out.event_tag  = r_req.requester_tag;
                                n_out.last       = 1'b1;
                            end else begin
                                w_rpush = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end else begin
                            w_give      = 1'b1;
                            w_give_slot = r_qhead;
                            n_out_valid             = 1'b1;
                            n_out.event_kind        = EV_DELIVERED;
                            n_out.event_tag         = r_req.requester_tag;
                            n_out.delivered_message = r_msg[r_qhead];
                            n_out.slot_used         = 3'(r_qhead);
                            n_out.last              = !w_any_wait;
                            n_step2                 = w_any_wait;
                            n_psel                  = w_pbest;
                        end
                    end
                    if (n_step2) begin
                        n_state = ST_STEP2;
                    end
                end
            end
            ST_STEP2: begin
                if (w_out_free) begin
                    n_state = ST_WAIT;
                    n_step2 = 1'b0;
                    n_out   = '0;
                    n_out_valid = 1'b1;
                    n_out.last  = 1'b1;
                    if (r_req.opcode == OP_SEND) begin
                        w_rpop      = 1'b1;
                        w_give      = 1'b1;
                        w_give_slot = r_qhead;
                        n_out.event_kind        = EV_DELIVERED;
                        n_out.event_tag         = w_rdata;
                        n_out.delivered_message = r_msg[r_qhead];
                        n_out.slot_used         = 3'(r_qhead);
                    end else begin
                        w_spop[r_psel] = 1'b1;
                        w_take         = 1'b1;
                        w_append       = 1'b1;
                        w_app_msg      = w_sdata[r_psel][31:0];
                        n_out.event_kind = EV_SENT;
                        n_out.event_tag  = w_sdata[r_psel][35:32];
                        n_out.slot_used  = 3'(r_fhead);
                    end
                end
            end
            ST_WAIT: begin
                if (r_out_valid && i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // link table updates; give and take never coincide in one step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_link[i] <= (i + 1 < SLOTS) ? SW'(i + 1) : '0;
            end
            r_fhead  <= '0;
            r_fcount <= FW'(SLOTS);
            r_qhead  <= '0;
            r_qtail  <= '0;
            r_qcount <= '0;
        end else begin
            if (w_take && w_append) begin
                r_fhead  <= r_link[r_fhead];
                r_fcount <= r_fcount - 1'b1;
                r_link[r_fhead] <= '0;
                if (r_qcount == '0) begin
                    r_qhead <= r_fhead;
                end else begin
                    r_link[r_qtail] <= r_fhead;
                end
                r_qtail  <= r_fhead;
                r_qcount <= r_qcount + 1'b1;
            end else if (w_give) begin
                r_qhead  <= r_link[w_give_slot];
                r_qcount <= r_qcount - 1'b1;
                r_link[w_give_slot] <= r_fhead;
                r_fhead  <= w_give_slot;
                r_fcount <= r_fcount + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_append) begin
            r_msg[r_fhead] <= w_app_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step2     <= 1'b0;
            r_psel      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step2     <= n_step2;
            r_psel      <= n_psel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == ST_IDLE && i_in_valid) begin
            r_req <= i_in_item;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a second event follows only a first one that is not last
    a_step2_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP2) |-> (r_out_valid && !r_out.last))
        else $error("second event without pending first");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_state == ST_IDLE) |-> 1'b0)
        else $error("idle with pending event");

    a_slot_conservation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_fcount) + 32'(r_qcount)) == SLOTS)
        else $error("slot count mismatch");
endmodule

### sim/pmbm_checker.sv
// pmbm_checker: watches both channels of the mailbox, predicts events and compares them
// depends on pmbm_pkg
`timescale 1ns / 1ps
module pmbm_checker
    import pmbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);
    logic [31:0] mb_msg [SLOTS];
    int          mb_link [SLOTS];
    int          q_head, q_tail, q_count, fr_head, fr_count;
    logic [35:0] snd_wait [PRIORITY_LEVELS][WAIT_DEPTH];
    int          snd_head [PRIORITY_LEVELS];
    int          snd_count [PRIORITY_LEVELS];
    logic [3:0]  rcv_wait [WAIT_DEPTH];
    int          rcv_head, rcv_count;
    t_out_item   expected_events[$];

    assign o_pending = expected_events.size();

    function automatic int take_slot();
        int s;
        s = fr_head;
        fr_head = mb_link[s];
        fr_count--;
        return s;
    endfunction

    function automatic void free_slot(int s);
        mb_link[s] = fr_head;
        fr_head = s;
        fr_count++;
    endfunction

    function automatic void enqueue_slot(int s);
        if (q_count == 0) begin
            q_head = s;
        end else begin
            mb_link[q_tail] = s;
        end
        q_tail = s;
        mb_link[s] = 0;
        q_count++;
    endfunction

    function automatic int dequeue_slot();
        int s;
        s = q_head;
        q_head = mb_link[s];
        q_count--;
        return s;
    endfunction

    function automatic void add_event(t_event k, logic [3:0] tag, logic [31:0] m, int s);
        t_out_item e;
        e.event_kind = k;
        e.event_tag = tag;
        e.delivered_message = m;
        e.slot_used = s[2:0];
        e.last = 1'b0;
        expected_events.push_back(e);
    endfunction

    function automatic void predict_request(t_in_item it);
        int n0, s, p, rt;
        logic [35:0] w;
        n0 = expected_events.size();
        if (it.opcode == OP_SEND) begin
            p = it.priority_req;
            if (p >= PRIORITY_LEVELS) begin
                add_event(EV_REJECTED, it.requester_tag, 0, 0);
            end else if (snd_count[p] > 0 || fr_count == 0) begin
                if (snd_count[p] >= WAIT_DEPTH) begin
                    add_event(EV_REJECTED, it.requester_tag, 0, 0);
                end else begin
                    snd_wait[p][(snd_head[p] + snd_count[p]) % WAIT_DEPTH] =
                        {it.requester_tag, it.message};
                    snd_count[p]++;
                end
            end else begin
                s = take_slot();
                mb_msg[s] = it.message;
                enqueue_slot(s);
                add_event(EV_SENT, it.requester_tag, 0, s);
                if (rcv_count > 0) begin
                    rt = rcv_wait[rcv_head];
                    rcv_head = (rcv_head + 1) % WAIT_DEPTH;
                    rcv_count--;
                    s = dequeue_slot();
                    add_event(EV_DELIVERED, rt[3:0], mb_msg[s], s);
                    free_slot(s);
                end
            end
        end else begin
            if (q_count == 0) begin
                if (rcv_count >= WAIT_DEPTH) begin
                    add_event(EV_REJECTED, it.requester_tag, 0, 0);
                end else begin
                    rcv_wait[(rcv_head + rcv_count) % WAIT_DEPTH] = it.requester_tag;
                    rcv_count++;
                end
            end else begin
                s = dequeue_slot();
                add_event(EV_DELIVERED, it.requester_tag, mb_msg[s], s);
                free_slot(s);
                for (p = 0; p < PRIORITY_LEVELS; p++) begin
                    if (snd_count[p] > 0) begin
                        w = snd_wait[p][snd_head[p]];
                        snd_head[p] = (snd_head[p] + 1) % WAIT_DEPTH;
                        snd_count[p]--;
                        s = take_slot();
                        mb_msg[s] = w[31:0];
                        enqueue_slot(s);
                        add_event(EV_SENT, w[35:32], 0, s);
                        break;
                    end
                end
            end
        end
        if (expected_events.size() > n0) begin
            expected_events[expected_events.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                mb_link[i] = (i + 1 < SLOTS) ? i + 1 : 0;
            end
            fr_head = 0;
            fr_count = SLOTS;
            q_head = 0;
            q_tail = 0;
            q_count = 0;
            for (int p = 0; p < PRIORITY_LEVELS; p++) begin
                snd_head[p] = 0;
                snd_count[p] = 0;
            end
            rcv_head = 0;
            rcv_count = 0;
            expected_events.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected event: %p", i_out_item);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_events.pop_front();
                    if (e !== i_out_item) begin
                        if (o_fail_count < 10) begin
                            $display("event differs: expected %p actual %p", e, i_out_item);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_request(i_in_item);
            end
        end
    end
endmodule

### sim/tb_top.sv
// tb_top: stimulus and verdict for the priority mailbox buffer manager
// depends on pmbm_pkg, priority_mailbox_buffer_manager and pmbm_checker
`timescale 1ns / 1ps
module tb_top;
    import pmbm_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    bit        calm = 1'b0;

    always #10 i_clk = ~i_clk;

    priority_mailbox_buffer_manager i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    pmbm_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("priority_mailbox_buffer_manager: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    task automatic send_item(logic op, logic [1:0] prio, logic [3:0] tag, logic [31:0] msg);
        t_in_item it;
        it.opcode = op;
        it.priority_req = prio;
        it.requester_tag = tag;
        it.message = msg;
        while (!calm && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int mode;
        logic op;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: fill, overflow waits, priorities, drain, receiver waits
        send_item(OP_SEND, 2'd3, 4'hF, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) begin
            send_item(OP_SEND, 2'(i % 3), 4'(i), (i == 0) ? 32'h0 : 32'hFFFF_FFFF - i);
        end
        send_item(OP_SEND, 2'd2, 4'hA, 32'hA5A5_5A5A);
        send_item(OP_SEND, 2'd0, 4'hB, 32'h5A5A_A5A5);
        for (int i = 0; i < 11; i++) begin
            send_item(OP_RECV, 2'd3, 4'(15 - i), 32'hFFFF_FFFF);
        end
        send_item(OP_SEND, 2'd1, 4'h0, 32'h1234_5678);
        // receiver wait list overflow
        for (int i = 0; i < 18; i++) begin
            send_item(OP_RECV, 2'd0, 4'(i), 32'h0);
        end
        for (int i = 0; i < 17; i++) begin
            send_item(OP_SEND, 2'd0, 4'(i), $urandom);
        end
        // sender wait list overflow on one priority
        for (int i = 0; i < 26; i++) begin
            send_item(OP_SEND, 2'd1, 4'(i), $urandom);
        end
        for (int i = 0; i < 26; i++) begin
            send_item(OP_RECV, 2'd0, 4'(i), $urandom);
        end
        for (int i = 0; i < 1050; i++) begin
            calm = (i >= 400 && i < 550);
            mode = (i / 100) % 3;
            case (mode)
                0: op = ($urandom_range(99) < 50);
                1: op = ($urandom_range(99) < 25);
                default: op = ($urandom_range(99) < 75);
            endcase
            send_item(op, ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)),
                      4'($urandom), $urandom);
        end
        in_valid <= 1'b0;
        calm = 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("priority_mailbox_buffer_manager: match");
        end else begin
            $display("priority_mailbox_buffer_manager: mismatch");
        end
        $finish;
    end
endmodule

### priority_mailbox_buffer_manager.f
rtl/core/pmbm_pkg.sv
rtl/core/pmbm_wait_fifo.sv
rtl/core/priority_mailbox_buffer_manager.sv
sim/pmbm_checker.sv
sim/tb_top.sv
